### rtl/rtcit_pkg.sv
// ============================================================================
// rtcit_pkg
// Shared types and constants for the real-time clock with interval timer.
// ============================================================================
`timescale 1ns / 1ps

package rtcit_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } rtcit_mode_t;

  // Bus byte offsets
  localparam logic [2:0] OFF_CMD  = 3'd0;
  localparam logic [2:0] OFF_DATA = 3'd4;

  // Command codes written to the command register
  localparam logic [31:0] CMD_LOAD_PERIOD = 32'd1;
  localparam logic [31:0] CMD_READ_SEC    = 32'd2;
  localparam logic [31:0] CMD_READ_MS     = 32'd3;
  localparam logic [31:0] CMD_WRITE_SEC   = 32'd4;
  localparam logic [31:0] CMD_WRITE_MS    = 32'd5;

  // Millisecond counter
  localparam int          MS_W      = 10;
  localparam logic [9:0]  MS_LAST   = 10'd999;
  localparam logic [31:0] MS_PER_S  = 32'd1000;

  // x / 1000 == (x * RECIP) >> RECIP_SHIFT, exact for every 32-bit x
  localparam logic [28:0] RECIP       = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          QUOT_W      = 23;

  // Registered input item, with the quotient by 1000 already formed
  typedef struct packed {
    rtcit_mode_t         mode;
    logic [2:0]          byte_offset;
    logic [31:0]         write_data;
    logic [QUOT_W-1:0]   quot;
  } rtcit_item_t;

  // One result
  typedef struct packed {
    logic        irq_pulse;
    logic        bus_error;
    logic [31:0] read_data;
  } rtcit_res_t;

endpackage

### rtl/rtc_with_interval_timer.sv
// ============================================================================
// rtc_with_interval_timer
// Real-time clock with periodic interval timer behind a command and a data
// register, driven by a stream of ticks, bus reads and bus writes.
// ============================================================================
// A request's result passes through the input register and then the result
//   register before it is presented.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset (rst_n low, synchronous) empties both stages and clears the clock,
//   the data register and the interval timer to zero.
`timescale 1ns / 1ps

module rtc_with_interval_timer
  import rtcit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] byte_offset, [34:3] write_data, rest 0
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] read_data, [32] bus_error,
                                  // [33] irq_pulse, rest 0
);

  logic        s1_valid_r;
  rtcit_item_t s1_item_r, s1_item_nxt;
  logic        out_valid_r;
  rtcit_res_t  out_res_r, out_res_nxt;

  logic        out_free;
  logic        exec_fire;
  logic [63:0] prod;

  // Handshake: result register frees the exec stage, exec frees the input
  assign out_free  = !out_valid_r || out_tready;
  assign exec_fire = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || exec_fire;

  // Quotient by 1000 of the written value, formed before the input register
  assign prod = 64'(in_tdata[34:3]) * 64'(RECIP);

  always_comb begin
    s1_item_nxt.mode        = rtcit_mode_t'(in_tuser);
    s1_item_nxt.byte_offset = in_tdata[2:0];
    s1_item_nxt.write_data  = in_tdata[34:3];
    s1_item_nxt.quot        = prod[RECIP_SHIFT +: QUOT_W];
  end

  rtcit_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (exec_fire),
    .item  (s1_item_r),
    .res   (out_res_nxt)
  );

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= s1_item_nxt;
    end
    if (exec_fire) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.irq_pulse, out_res_r.bus_error,
                       out_res_r.read_data};

endmodule

### rtl/rtcit_exec.sv
// ============================================================================
// rtcit_exec
// Clock, data register and interval timer state; applies one item per cycle while fire is high.
// ============================================================================
`timescale 1ns / 1ps

module rtcit_exec
  import rtcit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  rtcit_item_t item,
  output rtcit_res_t  res
);

  logic [31:0]     data_r,      data_nxt;
  logic [MS_W-1:0] data_mod_r,  data_mod_nxt;   // data_r mod 1000
  logic [31:0]     ivl_r,       ivl_nxt;
  logic [31:0]     left_r,      left_nxt;
  logic [31:0]     sec_r,       sec_nxt;
  logic [MS_W-1:0] sec_mod_r,   sec_mod_nxt;    // sec_r mod 1000
  logic [MS_W-1:0] ms_r,        ms_nxt;

  logic [31:0]     wr_rem;
  logic [MS_W-1:0] wr_mod;

  // write_data mod 1000 from the precomputed quotient
  assign wr_rem = item.write_data - 32'(32'(item.quot) * MS_PER_S);
  assign wr_mod = wr_rem[MS_W-1:0];

  // Next state and result
  always_comb begin
    data_nxt     = data_r;
    data_mod_nxt = data_mod_r;
    ivl_nxt      = ivl_r;
    left_nxt     = left_r;
    sec_nxt      = sec_r;
    sec_mod_nxt  = sec_mod_r;
    ms_nxt       = ms_r;
    res          = '0;
    unique case (item.mode)
      MODE_TICK: begin
        if (ms_r == MS_LAST) begin
          ms_nxt  = '0;
          sec_nxt = sec_r + 32'd1;
          // the 2^32 wrap lands on zero, whose remainder is zero as well
          if (sec_r == '1 || sec_mod_r == MS_LAST) begin
            sec_mod_nxt = '0;
          end else begin
            sec_mod_nxt = sec_mod_r + 10'd1;
          end
        end else begin
          ms_nxt = ms_r + 10'd1;
        end
        if (ivl_r != '0) begin
          if (left_r <= 32'd1) begin
            res.irq_pulse = 1'b1;
            left_nxt      = ivl_r;
          end else begin
            left_nxt = left_r - 32'd1;
          end
        end
      end
      MODE_READ: begin
        priority if (item.byte_offset == OFF_CMD) begin
          res.read_data = '0;
        end else if (item.byte_offset == OFF_DATA) begin
          res.read_data = data_r;
        end else begin
          res.bus_error = 1'b1;
        end
      end
      MODE_WRITE: begin
        priority if (item.byte_offset == OFF_CMD) begin
          unique case (item.write_data)
            CMD_LOAD_PERIOD: begin
              ivl_nxt  = data_r;
              left_nxt = data_r;
            end
            CMD_READ_SEC: begin
              data_nxt     = sec_r;
              data_mod_nxt = sec_mod_r;
            end
            CMD_READ_MS: begin
              data_nxt     = 32'(ms_r);
              data_mod_nxt = ms_r;
            end
            CMD_WRITE_SEC: begin
              sec_nxt     = data_r;
              sec_mod_nxt = data_mod_r;
            end
            CMD_WRITE_MS: begin
              ms_nxt = data_mod_r;
            end
            default: res.bus_error = 1'b1;
          endcase
        end else if (item.byte_offset == OFF_DATA) begin
          data_nxt     = item.write_data;
          data_mod_nxt = wr_mod;
        end else begin
          res.bus_error = 1'b1;
        end
      end
      default: ;  // unused mode: no effect
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r     <= '0;
      data_mod_r <= '0;
      ivl_r      <= '0;
      left_r     <= '0;
      sec_r      <= '0;
      sec_mod_r  <= '0;
      ms_r       <= '0;
    end else if (fire) begin
      data_r     <= data_nxt;
      data_mod_r <= data_mod_nxt;
      ivl_r      <= ivl_nxt;
      left_r     <= left_nxt;
      sec_r      <= sec_nxt;
      sec_mod_r  <= sec_mod_nxt;
      ms_r       <= ms_nxt;
    end
  end

endmodule

### rtl/rtcit_checker.sv
// ============================================================================
// rtcit_checker
// Port-level checks on the result channel of the clock block.
// ============================================================================
`timescale 1ns / 1ps

module rtcit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An interrupt result never reports a bus error and carries zero read data
  a_irq_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> !out_tdata[32] && out_tdata[31:0] == 32'd0)
    else $error("interrupt result carries bus fields");

  // Failed access returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("bus error with nonzero read data");

  // Padding stays clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0)
    else $error("result padding not zero");

endmodule

bind rtc_with_interval_timer rtcit_checker u_rtcit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
